/* src/scl_pkg.sv */
// ----------------------------------------------------------------------------
// scl_pkg: shared types and constants of the cache lookup engine
// Geometry, field widths, register indexes and the lookup request beat.
// ----------------------------------------------------------------------------
`default_nettype none

package scl_pkg;

  localparam int WAYS      = 4;
  localparam int WAY_W     = 2;
  localparam int SETS      = 64;
  localparam int SET_W     = 6;
  localparam int ADDR_W    = 48;
  localparam int OFF_W     = 6;
  localparam int TAG_W     = 45;
  localparam int CNT_W     = 32;
  localparam int CFG_W     = 3;
  localparam int CFG_IDX_W = 2;
  localparam int LFSR_W    = 16;
  localparam int OB_MIN    = 3;
  localparam int OB_MAX    = 6;
  localparam int IB_MAX    = 6;
  localparam int ORDER_W   = WAYS * WAY_W;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_RANDOM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS     = 2'd2;

  // One classified lookup, as it travels from the front to the back.
  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic [SET_W-1:0] set;
    logic [TAG_W-1:0] tag;
  } req_t;

  // Recency order after reset: way p at position p.
  function automatic logic [ORDER_W-1:0] order_reset();
    logic [ORDER_W-1:0] o;
    o = '0;
    for (int p = 0; p < WAYS; p++) begin
      o[p*WAY_W +: WAY_W] = WAY_W'(p);
    end
    return o;
  endfunction

endpackage

`default_nettype wire

/* src/scl_front.sv */
// ----------------------------------------------------------------------------
// scl_front: address classification
// Splits a read address into byte offset, set index and tag.
// ----------------------------------------------------------------------------
`default_nettype none

module scl_front import scl_pkg::*; (
  input  wire logic [ADDR_W-1:0] address,
  input  wire logic [CFG_W-1:0]  offset_bits,
  input  wire logic [CFG_W-1:0]  index_bits,
  output req_t                   req
);

  logic [CFG_W-1:0]  ob;
  logic [CFG_W-1:0]  ib;
  logic [ADDR_W-1:0] off_mask;
  logic [ADDR_W-1:0] set_mask;
  logic [ADDR_W-1:0] above_off;
  logic [ADDR_W-1:0] above_set;

  // Clamp the field widths to the supported ranges.
  always_comb begin
    ob = offset_bits;
    if (ob < CFG_W'(OB_MIN)) ob = CFG_W'(OB_MIN);
    if (ob > CFG_W'(OB_MAX)) ob = CFG_W'(OB_MAX);
    ib = index_bits;
    if (ib > CFG_W'(IB_MAX)) ib = CFG_W'(IB_MAX);
  end

  // Cut the address into its three fields.
  always_comb begin
    off_mask  = ~({ADDR_W{1'b1}} << ob);
    set_mask  = ~({ADDR_W{1'b1}} << ib);
    above_off = address >> ob;
    above_set = above_off >> ib;
    req.offset = OFF_W'(address & off_mask);
    req.set    = SET_W'(above_off & set_mask);
    req.tag    = TAG_W'(above_set);
  end

endmodule

`default_nettype wire

/* src/scl_fifo.sv */
// ----------------------------------------------------------------------------
// scl_fifo: two-entry request queue
// Decouples the classifying front from the lookup back.
// ----------------------------------------------------------------------------
`default_nettype none

module scl_fifo import scl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  req_t      push_data,
  input  wire logic pop,
  output req_t      pop_data,
  output logic      full,
  output logic      empty
);

  req_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  assign pop_data = mem_r[rd_ptr_r];
  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);

endmodule

`default_nettype wire

/* src/scl_back.sv */
// ----------------------------------------------------------------------------
// scl_back: tag compare and replacement
// Reads the set's tags and recency order, decides hit or victim, updates
// the stores, the LFSR and the counters, and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module scl_back import scl_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             replace_random,
  input  wire logic             q_empty,
  input  req_t                  q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_hit,
  output logic [WAY_W-1:0]      out_way,
  output logic [SET_W-1:0]      out_set_index,
  output logic [OFF_W-1:0]      out_byte_offset,
  output logic [TAG_W-1:0]      out_line_tag,
  output logic                  out_evicted_valid,
  output logic [CNT_W-1:0]      out_accesses,
  output logic [CNT_W-1:0]      out_misses
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_r, state_nxt;

  logic [WAYS*TAG_W-1:0] tag_mem [SETS];
  logic [ORDER_W-1:0]    rec_mem [SETS];
  logic [WAYS-1:0]       vld_r   [SETS];
  logic [SETS-1:0]       rec_ok_r;

  req_t                  ent_r;
  logic [WAYS*TAG_W-1:0] tag_row_r;
  logic [ORDER_W-1:0]    rec_row_r;
  logic [WAYS-1:0]       vld_row_r;
  logic                  rec_hit_r;
  logic [LFSR_W-1:0]     lfsr_r;
  logic [CNT_W-1:0]      acc_r;
  logic [CNT_W-1:0]      miss_r;

  logic [ORDER_W-1:0]    order;
  logic [WAY_W-1:0]      wpos   [WAYS];
  logic [WAYS-1:0]       vrow;
  logic [WAYS-1:0]       match;
  logic [WAYS-1:0]       inval;
  logic                  hit_c;
  logic                  any_inv;
  logic [WAY_W-1:0]      hpos;
  logic [WAY_W-1:0]      ipos;
  logic [WAY_W-1:0]      pos;
  logic [WAY_W-1:0]      way_c;
  logic                  evict_c;
  logic                  lfsr_step;
  logic [LFSR_W-1:0]     lfsr_new;
  logic [ORDER_W-1:0]    order_new;
  logic [WAYS*TAG_W-1:0] tag_row_new;

  // Sequencer: take a request, look it up, deliver the beat.
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: state_nxt = S_OUT;
      S_OUT:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Compare the tag against the set in recency order.
  always_comb begin
    order = rec_hit_r ? rec_row_r : order_reset();
    vrow  = vld_row_r;
    for (int p = 0; p < WAYS; p++) begin
      wpos[p]  = order[p*WAY_W +: WAY_W];
      match[p] = vrow[wpos[p]] && (tag_row_r[wpos[p]*TAG_W +: TAG_W] == ent_r.tag);
      inval[p] = !vrow[wpos[p]];
    end
    hit_c   = 1'b0;
    any_inv = 1'b0;
    hpos    = '0;
    ipos    = '0;
    for (int p = WAYS - 1; p >= 0; p--) begin
      if (match[p]) begin
        hit_c = 1'b1;
        hpos  = WAY_W'(p);
      end
      if (inval[p]) begin
        any_inv = 1'b1;
        ipos    = WAY_W'(p);
      end
    end
  end

  // Victim choice and the updated recency order and tag row.
  always_comb begin
    lfsr_new  = {lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5], lfsr_r[LFSR_W-1:1]};
    evict_c   = !hit_c && !any_inv;
    lfsr_step = evict_c && replace_random;
    if (hit_c)          pos = hpos;
    else if (any_inv)   pos = ipos;
    else if (replace_random) pos = lfsr_new[WAY_W-1:0];
    else                pos = WAY_W'(WAYS - 1);
    way_c = wpos[pos];
    for (int p = 0; p < WAYS; p++) begin
      if (p == 0)
        order_new[p*WAY_W +: WAY_W] = way_c;
      else if (WAY_W'(p) <= pos)
        order_new[p*WAY_W +: WAY_W] = order[(p-1)*WAY_W +: WAY_W];
      else
        order_new[p*WAY_W +: WAY_W] = order[p*WAY_W +: WAY_W];
    end
    tag_row_new = tag_row_r;
    tag_row_new[way_c*TAG_W +: TAG_W] = ent_r.tag;
  end

  // Control state, valid bits, LFSR and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rec_ok_r <= '0;
      lfsr_r   <= LFSR_SEED;
      acc_r    <= '0;
      miss_r   <= '0;
      for (int s = 0; s < SETS; s++) vld_r[s] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_LOOK) begin
        rec_ok_r[ent_r.set] <= 1'b1;
        acc_r <= acc_r + CNT_W'(1);
        if (!hit_c) begin
          miss_r <= miss_r + CNT_W'(1);
          vld_r[ent_r.set][way_c] <= 1'b1;
        end
        if (lfsr_step) lfsr_r <= lfsr_new;
      end
    end
  end

  // Tag and recency memories: registered read on pop, write after lookup.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r     <= q_data;
      tag_row_r <= tag_mem[q_data.set];
      rec_row_r <= rec_mem[q_data.set];
      vld_row_r <= vld_r[q_data.set];
      rec_hit_r <= rec_ok_r[q_data.set];
    end
    if (state_r == S_LOOK) begin
      rec_mem[ent_r.set] <= order_new;
      if (!hit_c) tag_mem[ent_r.set] <= tag_row_new;
    end
  end

  // Result beat register.
  always_ff @(posedge clk) begin
    if (state_r == S_LOOK) begin
      out_hit           <= hit_c;
      out_way           <= way_c;
      out_set_index     <= ent_r.set;
      out_byte_offset   <= ent_r.offset;
      out_line_tag      <= ent_r.tag;
      out_evicted_valid <= evict_c;
      out_accesses      <= acc_r + CNT_W'(1);
      out_misses        <= miss_r + CNT_W'(!hit_c);
    end
  end

  assign out_valid = (state_r == S_OUT);

`ifndef SYNTHESIS
  a_acc_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK) |=> (acc_r == $past(acc_r) + CNT_W'(1)))
    else $error("access count did not advance by one on a lookup");
  a_hit_no_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK && hit_c) |=> (miss_r == $past(miss_r) && !out_evicted_valid))
    else $error("hit counted as miss or reported an eviction");
  a_beat_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_way) && $stable(out_misses)))
    else $error("result beat changed while stalled");
`endif

endmodule

`default_nettype wire

/* src/set_assoc_cache_lookup.sv */
// ----------------------------------------------------------------------------
// set_assoc_cache_lookup: tag and replacement engine of a read cache
// Four-way set-associative lookup with LRU or pseudo-random replacement.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   in_address
//   out_     output     out_valid / out_ready hit, way, set, offset, tag, ...
//   cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// The front classifies an address and queues it in a two-entry queue in the
// beat it is accepted. The back handles one lookup at a time: memory read,
// compare and update, result beat; it pops the next request only after the
// beat is taken. Reset is synchronous; it clears valid bits and counters,
// marks recency rows unset and reloads the LFSR seed. A stalled result holds
// the back; the front keeps accepting until the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_lookup import scl_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [ADDR_W-1:0]    in_address,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_hit,
  output logic [WAY_W-1:0]          out_way,
  output logic [SET_W-1:0]          out_set_index,
  output logic [OFF_W-1:0]          out_byte_offset,
  output logic [TAG_W-1:0]          out_line_tag,
  output logic                      out_evicted_valid,
  output logic [CNT_W-1:0]          out_accesses,
  output logic [CNT_W-1:0]          out_misses,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  logic             rr_r;
  logic [CFG_W-1:0] ob_r;
  logic [CFG_W-1:0] ib_r;
  req_t             front_req;
  req_t             q_data;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rr_r <= 1'b0;
      ob_r <= CFG_W'(OB_MAX);
      ib_r <= CFG_W'(IB_MAX);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REPLACE_RANDOM: rr_r <= cfg_wdata[0];
        CFG_OFFSET_BITS:    ob_r <= cfg_wdata;
        CFG_INDEX_BITS:     ib_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ready = !q_full;

  scl_front u_front (
    .address     (in_address),
    .offset_bits (ob_r),
    .index_bits  (ib_r),
    .req         (front_req)
  );

  scl_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && in_ready),
    .push_data (front_req),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  scl_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .replace_random    (rr_r),
    .q_empty           (q_empty),
    .q_data            (q_data),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_way           (out_way),
    .out_set_index     (out_set_index),
    .out_byte_offset   (out_byte_offset),
    .out_line_tag      (out_line_tag),
    .out_evicted_valid (out_evicted_valid),
    .out_accesses      (out_accesses),
    .out_misses        (out_misses)
  );

endmodule

`default_nettype wire

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the set-associative cache lookup engine
// Drives read addresses through the valid/ready input channel, predicts each
// lookup result with a local model of tags, valid bits, recency order, LFSR
// and counters, and compares every result beat field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import scl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    logic [SET_W-1:0] set_index;
    logic [OFF_W-1:0] byte_offset;
    logic [TAG_W-1:0] line_tag;
    logic             evicted_valid;
    logic [CNT_W-1:0] accesses;
    logic [CNT_W-1:0] misses;
  } lookup_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [ADDR_W-1:0]    in_address;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_hit;
  logic [WAY_W-1:0]     out_way;
  logic [SET_W-1:0]     out_set_index;
  logic [OFF_W-1:0]     out_byte_offset;
  logic [TAG_W-1:0]     out_line_tag;
  logic                 out_evicted_valid;
  logic [CNT_W-1:0]     out_accesses;
  logic [CNT_W-1:0]     out_misses;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  set_assoc_cache_lookup i_dut (.*);

  // Model state of the cache.
  logic [TAG_W-1:0]  mdl_tag [SETS][WAYS];
  logic              mdl_vld [SETS][WAYS];
  logic [WAY_W-1:0]  mdl_order [SETS][WAYS];
  logic [LFSR_W-1:0] mdl_lfsr;
  logic [CNT_W-1:0]  mdl_acc;
  logic [CNT_W-1:0]  mdl_miss;
  logic              mdl_rand;
  logic [2:0]        mdl_ob;
  logic [2:0]        mdl_ib;

  lookup_t expected_q[$];
  int      n_errors;
  int      n_results;
  int      n_hits;
  int      n_evicts;
  int      send_idle_pct;
  int      recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Timeout after %0d results", n_results);
    $display("Some tests failed");
    $finish;
  end

  task automatic model_reset();
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        mdl_tag[s][w]   = '0;
        mdl_vld[s][w]   = 1'b0;
        mdl_order[s][w] = WAY_W'(w);
      end
    end
    mdl_lfsr = LFSR_SEED;
    mdl_acc  = '0;
    mdl_miss = '0;
    mdl_rand = 1'b0;
    mdl_ob   = 3'd6;
    mdl_ib   = 3'd6;
  endtask

  // Works out the lookup result of one address and updates the model.
  function automatic lookup_t predict_lookup(logic [ADDR_W-1:0] addr);
    lookup_t          r;
    int               ob;
    int               ib;
    int               pos;
    int               s;
    logic             found;
    logic [WAY_W-1:0] w;
    logic [ADDR_W-1:0] tag;
    ob = (mdl_ob < OB_MIN) ? OB_MIN : ((mdl_ob > OB_MAX) ? OB_MAX : int'(mdl_ob));
    ib = (mdl_ib > IB_MAX) ? IB_MAX : int'(mdl_ib);
    r = '0;
    r.byte_offset = OFF_W'(addr & ((48'd1 << ob) - 1));
    s = int'((addr >> ob) & ((48'd1 << ib) - 1));
    tag = addr >> (ob + ib);
    mdl_acc++;
    found = 1'b0;
    pos = 0;
    for (int p = 0; p < WAYS; p++) begin
      if (!found && mdl_vld[s][mdl_order[s][p]] &&
          mdl_tag[s][mdl_order[s][p]] == TAG_W'(tag)) begin
        found = 1'b1;
        pos = p;
      end
    end
    if (!found) begin
      mdl_miss++;
      pos = WAYS;
      for (int p = WAYS - 1; p >= 0; p--) begin
        if (!mdl_vld[s][mdl_order[s][p]]) pos = p;
      end
      if (pos == WAYS) begin
        r.evicted_valid = 1'b1;
        if (mdl_rand) begin
          mdl_lfsr = {mdl_lfsr[0] ^ mdl_lfsr[2] ^ mdl_lfsr[3] ^ mdl_lfsr[5],
                      mdl_lfsr[LFSR_W-1:1]};
          pos = int'(mdl_lfsr % WAYS);
        end else begin
          pos = WAYS - 1;
        end
      end
      mdl_tag[s][mdl_order[s][pos]] = TAG_W'(tag);
      mdl_vld[s][mdl_order[s][pos]] = 1'b1;
    end
    // Move the chosen way to the front of the recency order.
    w = mdl_order[s][pos];
    for (int p = pos; p > 0; p--) mdl_order[s][p] = mdl_order[s][p-1];
    mdl_order[s][0] = w;
    r.hit       = found;
    r.way       = w;
    r.set_index = SET_W'(s);
    r.line_tag  = TAG_W'(tag);
    r.accesses  = mdl_acc;
    r.misses    = mdl_miss;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("Mismatch on %s at result %0d: got %0h, expected %0h",
             field, n_results, got, want);
    n_errors++;
  endtask

  // Result checker and receiver stalls.
  always @(posedge clk) begin
    lookup_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", 64'(out_accesses), 64'd0);
      end else begin
        e = expected_q.pop_front();
        if (out_hit !== e.hit) report_mismatch("hit", 64'(out_hit), 64'(e.hit));
        if (out_way !== e.way) report_mismatch("way", 64'(out_way), 64'(e.way));
        if (out_set_index !== e.set_index)
          report_mismatch("set_index", 64'(out_set_index), 64'(e.set_index));
        if (out_byte_offset !== e.byte_offset)
          report_mismatch("byte_offset", 64'(out_byte_offset), 64'(e.byte_offset));
        if (out_line_tag !== e.line_tag)
          report_mismatch("line_tag", 64'(out_line_tag), 64'(e.line_tag));
        if (out_evicted_valid !== e.evicted_valid)
          report_mismatch("evicted_valid", 64'(out_evicted_valid), 64'(e.evicted_valid));
        if (out_accesses !== e.accesses)
          report_mismatch("accesses", 64'(out_accesses), 64'(e.accesses));
        if (out_misses !== e.misses)
          report_mismatch("misses", 64'(out_misses), 64'(e.misses));
        n_hits   += e.hit;
        n_evicts += e.evicted_valid;
      end
      n_results++;
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Sends one address beat, with a random idle gap first, and records its result.
  // Valid stays high after acceptance so that beats can follow back to back.
  task automatic send_address(logic [ADDR_W-1:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_address <= addr;
    expected_q.push_back(predict_lookup(addr));
    do @(posedge clk); while (!in_ready);
  endtask

  // Waits until every result is in and the pipeline has drained.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_REPLACE_RANDOM) mdl_rand = val[0];
    else if (idx == CFG_OFFSET_BITS) mdl_ob = val;
    else if (idx == CFG_INDEX_BITS) mdl_ib = val;
  endtask

  // Address that hits one of a few tags in a small group of sets.
  function automatic logic [ADDR_W-1:0] local_address();
    logic [ADDR_W-1:0] a;
    a = 48'({$urandom, $urandom});
    a[47:12] = 36'($urandom_range(6));
    a[11:6]  = 6'($urandom_range(3));
    if ($urandom_range(3) == 0) a = a << $urandom_range(3, 6);
    if ($urandom_range(9) == 0) a = 48'({$urandom, $urandom});
    return a;
  endfunction

  task automatic test_directed();
    logic [ADDR_W-1:0] a;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_address('0);
    send_address('1);
    send_address(48'h8000_0000_0000);
    send_address(48'h0000_0000_003F);
    send_address('0);
    // Fill one set beyond its ways, then revisit the evicted and kept lines.
    for (int i = 1; i <= 5; i++) send_address(48'(i) << 12);
    send_address(48'h1000);
    send_address(48'h5000);
    drain();
    // Out-of-range widths: offset 0 acts as 3, index 7 acts as 6.
    write_config(CFG_OFFSET_BITS, 3'd0);
    write_config(CFG_INDEX_BITS, 3'd7);
    send_address(48'hFFFF_FFFF_FFF8);
    send_address(48'h0000_0000_0208);
    drain();
    write_config(CFG_OFFSET_BITS, 3'd7);
    write_config(CFG_INDEX_BITS, 3'd0);
    send_address(48'hABCD_1234_5678);
    send_address(48'hAAAA_5555_AAAA);
    drain();
    // Random victims in a single set.
    write_config(CFG_REPLACE_RANDOM, 3'd1);
    for (int i = 0; i < 8; i++) begin
      a = 48'(i + 10) << 6;
      send_address(a);
    end
    drain();
  endtask

  task automatic test_random_phase(bit rnd, logic [2:0] ob, logic [2:0] ib,
                                   int idle, int stall, int n);
    write_config(CFG_REPLACE_RANDOM, {2'b00, rnd});
    write_config(CFG_OFFSET_BITS, ob);
    write_config(CFG_INDEX_BITS, ib);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) send_address(local_address());
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_address = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    n_errors = 0;
    n_results = 0;
    n_hits = 0;
    n_evicts = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    model_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_directed();
    test_random_phase(1'b0, 3'd6, 3'd6, 0, 0, 200);
    test_random_phase(1'b1, 3'd3, 3'd0, 84, 0, 200);
    test_random_phase(1'b0, 3'd4, 3'd2, 0, 84, 200);
    test_random_phase(1'b1, 3'd5, 3'd1, 14, 14, 200);
    test_random_phase(1'b0, 3'd3, 3'd6, 0, 0, 200);

    $display("Checked %0d lookups: %0d hits, %0d evictions", n_results, n_hits, n_evicts);
    $display("Covered LRU and random replacement, width extremes and idling phases");
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* set_assoc_cache_lookup.f */
src/scl_pkg.sv
src/scl_front.sv
src/scl_fifo.sv
src/scl_back.sv
src/set_assoc_cache_lookup.sv
sim/tb.sv
